@@ hw/rtl/ir_remote_frame_transmitter_assert.svh @@
// ----------------------------------------------------------------------------
// IR remote frame transmitter assertion macros
// Clocked, reset-qualified helpers for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef IR_REMOTE_FRAME_TRANSMITTER_ASSERT_SVH
`define IR_REMOTE_FRAME_TRANSMITTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define IRTX_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("irtx assertion failed");

// antecedent implies consequent in the next cycle
`define IRTX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("irtx assertion failed");

`endif

@@ hw/rtl/irtx_pkg.sv @@
// ----------------------------------------------------------------------------
// IR remote frame transmitter package
// Shared types, register indexes and key lookup tables.
// ----------------------------------------------------------------------------
package irtx_pkg;

  localparam int unsigned FrameBits = 16;
  localparam int unsigned KeyW      = 8;

  // configuration register indexes
  localparam logic [2:0] CfgChannel    = 3'd0;
  localparam logic [2:0] CfgPulse      = 3'd1;
  localparam logic [2:0] CfgLowSpace   = 3'd2;
  localparam logic [2:0] CfgHighSpace  = 3'd3;
  localparam logic [2:0] CfgStartSpace = 3'd4;
  localparam logic [2:0] CfgSlot       = 3'd5;

  localparam logic [KeyW-1:0] KeyFirst = 8'd49;
  localparam logic [KeyW-1:0] KeyLast  = 8'd57;

  // frame encoder result
  typedef struct packed {
    logic                 ok;
    logic [FrameBits-1:0] frame;
  } enc_res_t;

  // one result item, led in the lowest bit
  typedef struct packed {
    logic                 done_res;
    logic [FrameBits-1:0] frame;
    logic                 rejected;
    logic                 accepted;
    logic                 busy_res;
    logic                 led;
  } res_t;

  localparam int unsigned ResW   = $bits(res_t);
  localparam int unsigned TdataW = ((ResW + 7) / 8) * 8;

  // left/right nibble per key offset
  function automatic logic [3:0] lr_nibble(input logic [3:0] idx);
    logic [3:0] n;
    case (idx)
      4'd0:    n = 4'd7;
      4'd1:    n = 4'd0;
      4'd2:    n = 4'd9;
      4'd3:    n = 4'd7;
      4'd4:    n = 4'd8;
      4'd5:    n = 4'd9;
      4'd6:    n = 4'd7;
      4'd7:    n = 4'd0;
      4'd8:    n = 4'd9;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // forward/back nibble per key offset
  function automatic logic [3:0] fb_nibble(input logic [3:0] idx);
    logic [3:0] n;
    case (idx)
      4'd0:    n = 4'd9;
      4'd1:    n = 4'd9;
      4'd2:    n = 4'd9;
      4'd3:    n = 4'd0;
      4'd4:    n = 4'd8;
      4'd5:    n = 4'd0;
      4'd6:    n = 4'd7;
      4'd7:    n = 4'd7;
      4'd8:    n = 4'd7;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

@@ hw/rtl/irtx_frame_enc.sv @@
// ----------------------------------------------------------------------------
// IR remote frame encoder
// Checks a key and composes header, direction nibbles and the LRC nibble.
// ----------------------------------------------------------------------------
module irtx_frame_enc import irtx_pkg::*; (
  input  logic [KeyW-1:0] key_i,
  input  logic [1:0]      chan_bits_i,  // effective channel minus one
  output enc_res_t        enc_o
);

  logic [KeyW-1:0] offs;
  logic [3:0]      n1, n2, n3, lrc;

  assign offs = key_i - KeyFirst;
  assign n1   = {2'b01, chan_bits_i};
  assign n2   = lr_nibble(offs[3:0]);
  assign n3   = fb_nibble(offs[3:0]);
  assign lrc  = 4'hF ^ n1 ^ n2 ^ n3;

  assign enc_o.ok    = (key_i >= KeyFirst) && (key_i <= KeyLast);
  assign enc_o.frame = {n1, n2, n3, lrc};

endmodule

@@ hw/rtl/ir_remote_frame_transmitter.sv @@
// ----------------------------------------------------------------------------
// IR remote frame transmitter
// Pulse-distance frame generator driven by carrier ticks and key commands.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | payload
//  s_axis   | in  | s_axis_tvalid/tready   | tuser: action, tdata: keycode
//  m_axis   | out | m_axis_tvalid/tready   | tdata: led..done_res
//  cfg      | in  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item per cycle unless both output entries are full: an input register
// feeds the tick/command update, and the result lands in a two-entry output
// buffer; both the input and the result are registered.
// Input stalls only when both output entries are full.
// Reset puts the sequencer idle with default timing registers.
// ----------------------------------------------------------------------------
`include "ir_remote_frame_transmitter_assert.svh"

module ir_remote_frame_transmitter import irtx_pkg::*; #(
  parameter int unsigned REPEATS = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [KeyW-1:0]   s_axis_tdata,   // [7:0] keycode
  input  logic              s_axis_tuser,   // [0] action
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [0] led, [1] busy_res, [2] accepted, [3] rejected, [19:4] frame, [20] done_res
  output logic [TdataW-1:0] m_axis_tdata,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [10:0]       cfg_data_i
);

  localparam int unsigned RepW    = (REPEATS > 1) ? $clog2(REPEATS) : 1;
  localparam int unsigned RepCntW = RepW + 1;

  typedef enum logic [1:0] {PhIdle, PhGap, PhPulse, PhSpace} phase_e;

  // configuration
  logic [2:0]  channel_q;
  logic [7:0]  pulse_q, low_sp_q, high_sp_q, start_sp_q;
  logic [10:0] slot_q;

  // input stage
  logic            in_valid_q, in_act_q;
  logic [KeyW-1:0] in_key_q;
  logic            adv;

  // sequencer state
  phase_e               phase_q, phase_d;
  logic [14:0]          tick_q, tick_d;
  logic [4:0]           bit_q, bit_d;
  logic [RepW-1:0]      rep_q, rep_d;
  logic [FrameBits-1:0] frame_q, frame_d;
  logic [KeyW-1:0]      send_key_q, send_key_d, pend_key_q, pend_key_d;
  logic                 pend_q, pend_d;

  // output buffer
  logic ov_q, sv_q, pop;
  res_t od_q, sd_q, res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q  <= 3'd1;
      pulse_q    <= 8'd6;
      low_sp_q   <= 8'd10;
      high_sp_q  <= 8'd21;
      start_sp_q <= 8'd39;
      slot_q     <= 11'd608;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgChannel:    channel_q  <= cfg_data_i[2:0];
        CfgPulse:      pulse_q    <= cfg_data_i[7:0];
        CfgLowSpace:   low_sp_q   <= cfg_data_i[7:0];
        CfgHighSpace:  high_sp_q  <= cfg_data_i[7:0];
        CfgStartSpace: start_sp_q <= cfg_data_i[7:0];
        CfgSlot:       slot_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- timing helpers ----
  logic [2:0]  eff_ch;
  logic [2:0]  rep3;
  logic [3:0]  gap_mul;
  logic [14:0] gap_len, space_len, phase_len;
  logic [4:0]  bsel;
  logic        gap0_zero;

  always_comb begin
    if (channel_q < 3'd1)      eff_ch = 3'd1;
    else if (channel_q > 3'd4) eff_ch = 3'd4;
    else                       eff_ch = channel_q;
  end

  assign rep3 = 3'(rep_q);

  always_comb begin
    if (rep3 == 3'd0)      gap_mul = 4'd4 - {1'b0, eff_ch};
    else if (rep3 <= 3'd2) gap_mul = 4'd5;
    else                   gap_mul = 4'd6 + {eff_ch, 1'b0};
  end

  assign gap_len = 15'(gap_mul) * 15'(slot_q);

  // the first repetition's gap is empty on channel 4; all gaps are empty with slot 0
  assign gap0_zero = (slot_q == 11'd0) || (eff_ch == 3'd4);

  assign bsel = 5'(FrameBits) - bit_q;

  always_comb begin
    if (bit_q == 5'd0 || bit_q > 5'(FrameBits)) space_len = 15'(start_sp_q);
    else if (frame_q[bsel[3:0]])                space_len = 15'(high_sp_q);
    else                                        space_len = 15'(low_sp_q);
  end

  always_comb begin
    case (phase_q)
      PhGap:   phase_len = gap_len;
      PhPulse: phase_len = 15'(pulse_q);
      PhSpace: phase_len = space_len;
      default: phase_len = 15'd0;
    endcase
  end

  // ---- frame encoder ----
  logic [KeyW-1:0] enc_key;
  logic [2:0]      ch_m1;
  enc_res_t        enc;

  assign enc_key = in_act_q ? in_key_q : pend_key_q;
  assign ch_m1   = eff_ch - 3'd1;

  irtx_frame_enc u_enc (
    .key_i       (enc_key),
    .chan_bits_i (ch_m1[1:0]),
    .enc_o       (enc)
  );

  // ---- next state ----
  logic [14:0]        tick_inc;
  logic [RepCntW-1:0] rep_inc;
  logic               led, accepted, rejected, done;

  assign tick_inc = tick_q + 15'd1;
  assign rep_inc  = RepCntW'(rep_q) + RepCntW'(1);

  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    bit_d      = bit_q;
    rep_d      = rep_q;
    frame_d    = frame_q;
    send_key_d = send_key_q;
    pend_key_d = pend_key_q;
    pend_d     = pend_q;
    accepted   = 1'b0;
    rejected   = 1'b0;
    done       = 1'b0;
    led        = (phase_q == PhPulse);

    if (in_act_q) begin
      if (phase_q == PhIdle) begin
        if (enc.ok) begin
          accepted   = 1'b1;
          frame_d    = enc.frame;
          send_key_d = in_key_q;
          rep_d      = '0;
          pend_d     = 1'b0;
          tick_d     = '0;
          bit_d      = '0;
          phase_d    = gap0_zero ? PhPulse : PhGap;
        end else begin
          rejected = 1'b1;
        end
      end else begin
        pend_key_d = in_key_q;
        pend_d     = 1'b1;
      end
      // a command reports the level the next tick drives
      led = (phase_d == PhPulse);
    end else if (phase_q != PhIdle) begin
      if (tick_inc >= phase_len) begin
        tick_d = '0;
        case (phase_q)
          PhGap:   phase_d = PhPulse;
          PhPulse: phase_d = PhSpace;
          default: begin
            bit_d = bit_q + 5'd1;
            if (bit_q + 5'd1 <= 5'(FrameBits + 1)) begin
              phase_d = PhPulse;
            end else if (pend_q && pend_key_q != send_key_q) begin
              // abort: switch to the newer key or give up
              done   = 1'b1;
              pend_d = 1'b0;
              if (enc.ok) begin
                accepted   = 1'b1;
                frame_d    = enc.frame;
                send_key_d = pend_key_q;
                rep_d      = '0;
                bit_d      = '0;
                phase_d    = gap0_zero ? PhPulse : PhGap;
              end else begin
                rejected = 1'b1;
                bit_d    = '0;
                phase_d  = PhIdle;
              end
            end else begin
              pend_d = 1'b0;
              bit_d  = '0;
              if (rep_inc >= RepCntW'(REPEATS)) begin
                done    = 1'b1;
                phase_d = PhIdle;
              end else begin
                rep_d   = RepW'(rep_inc);
                phase_d = (slot_q == 11'd0) ? PhPulse : PhGap;
              end
            end
          end
        endcase
      end else begin
        tick_d = tick_inc;
      end
    end
  end

  always_comb begin
    res.led      = led;
    res.busy_res = (phase_d != PhIdle);
    res.accepted = accepted;
    res.rejected = rejected;
    res.frame    = frame_d;
    res.done_res = done;
  end

  // ---- input register ----
  assign adv           = in_valid_q && !sv_q;
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_act_q <= s_axis_tuser;
      in_key_q <= s_axis_tdata;
    end
  end

  // ---- sequencer state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      tick_q     <= '0;
      bit_q      <= '0;
      rep_q      <= '0;
      frame_q    <= '0;
      send_key_q <= '0;
      pend_key_q <= '0;
      pend_q     <= 1'b0;
    end else if (adv) begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      bit_q      <= bit_d;
      rep_q      <= rep_d;
      frame_q    <= frame_d;
      send_key_q <= send_key_d;
      pend_key_q <= pend_key_d;
      pend_q     <= pend_d;
    end
  end

  // ---- two-entry output buffer ----
  assign pop = ov_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (sv_q) begin
      if (pop) sv_q <= 1'b0;
    end else if (ov_q && !pop) begin
      if (adv) sv_q <= 1'b1;
    end else begin
      ov_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      if (pop) od_q <= sd_q;
    end else if (ov_q && !pop) begin
      if (adv) sd_q <= res;
    end else if (adv) begin
      od_q <= res;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = TdataW'(od_q);

  // ---- checks ----
  `IRTX_ASSERT_SAME(a_skid_needs_head, clk_i, rst_ni, sv_q, ov_q)
  `IRTX_ASSERT_SAME(a_acc_rej_excl, clk_i, rst_ni, ov_q, !(od_q.accepted && od_q.rejected))
  `IRTX_ASSERT_SAME(a_idle_clean, clk_i, rst_ni, phase_q == PhIdle,
                    (tick_q == 15'd0) && (bit_q == 5'd0))
  `IRTX_ASSERT_SAME(a_bit_range, clk_i, rst_ni, phase_q != PhIdle,
                    bit_q <= 5'(FrameBits + 1))
  `IRTX_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, ov_q && !m_axis_tready, ov_q)

endmodule

@@ test/tb_ir_remote_frame_transmitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR remote frame transmitter testbench
// Streams carrier ticks and key commands into the transmitter and predicts
// every result item by item: LED level, busy, accept/reject, frame, done.
// Covers key decode, pending keys, register edge values and changes made
// while a frame sequence is running, under several stall patterns.
// ----------------------------------------------------------------------------
module tb_ir_remote_frame_transmitter;
  import irtx_pkg::*;

  localparam int unsigned TimeoutCycles = 400000;
  localparam int unsigned Repeats       = 5;
  localparam logic [7:0]  KeyQuit       = 8'd113;
  localparam logic        ActTick       = 1'b0;
  localparam logic        ActKey        = 1'b1;

  // key lookup nibbles, key offset 0 in the lowest bits
  localparam logic [35:0] LrNibs = {4'd9, 4'd0, 4'd7, 4'd9, 4'd8, 4'd7, 4'd9, 4'd0, 4'd7};
  localparam logic [35:0] FbNibs = {4'd7, 4'd7, 4'd7, 4'd0, 4'd8, 4'd0, 4'd9, 4'd9, 4'd9};

  typedef enum logic [1:0] {TxIdle, TxGap, TxPulse, TxSpace} tx_phase_e;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [KeyW-1:0]   s_axis_tdata;
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [TdataW-1:0] m_axis_tdata;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i;
  logic [10:0]       cfg_data_i;

  ir_remote_frame_transmitter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // transmitter shadow: timing registers and sequencer state
  logic [2:0]  chan_r;
  logic [7:0]  pulse_r, low_r, high_r, start_r;
  logic [10:0] slot_r;
  tx_phase_e   tx_phase;
  logic [14:0] tick_cnt;
  logic [4:0]  bit_idx;
  logic [2:0]  rep_idx;
  logic [15:0] frame_q;
  logic [7:0]  cur_key, queued_key;
  logic        queued;

  res_t tx_results_q[$];
  int   errors;
  int   idle_pct, stall_pct, cmd_permille;
  int   cycle_cnt;

  function automatic int unsigned eff_chan();
    if (chan_r == 3'd0) return 1;
    if (chan_r > 3'd4) return 4;
    return chan_r;
  endfunction

  function automatic int unsigned gap_ticks(input logic [2:0] rep);
    if (rep == 3'd0) return (4 - eff_chan()) * slot_r;
    if (rep <= 3'd2) return 5 * slot_r;
    return (6 + 2 * eff_chan()) * slot_r;
  endfunction

  function automatic void start_gap();
    tick_cnt = '0;
    bit_idx  = '0;
    tx_phase = (gap_ticks(rep_idx) == 0) ? TxPulse : TxGap;
  endfunction

  function automatic logic load_key(input logic [7:0] key);
    int         ofs;
    logic [3:0] hdr, lr, fb;
    if (key < KeyFirst || key > KeyLast) return 1'b0;
    ofs     = key - KeyFirst;
    hdr     = 4'h4 | 4'(eff_chan() - 1);
    lr      = LrNibs[ofs*4 +: 4];
    fb      = FbNibs[ofs*4 +: 4];
    frame_q = {hdr, lr, fb, 4'hf ^ hdr ^ lr ^ fb};
    cur_key = key;
    rep_idx = '0;
    queued  = 1'b0;
    start_gap();
    return 1'b1;
  endfunction

  // one tick or key command through the sequencer, returns its result
  function automatic res_t advance_transmitter(input logic act, input logic [7:0] key);
    res_t        r;
    int unsigned len;
    r = '0;
    if (act == ActKey) begin
      if (tx_phase == TxIdle) begin
        if (load_key(key)) r.accepted = 1'b1;
        else r.rejected = 1'b1;
      end else begin
        queued_key = key;
        queued     = 1'b1;
      end
      r.led = (tx_phase == TxPulse);
    end else begin
      r.led = (tx_phase == TxPulse);
      if (tx_phase != TxIdle) begin
        tick_cnt = tick_cnt + 15'd1;
        case (tx_phase)
          TxGap:   len = gap_ticks(rep_idx);
          TxPulse: len = pulse_r;
          default: begin
            if (bit_idx == 5'd0 || bit_idx > FrameBits) len = start_r;
            else if (frame_q[16 - bit_idx]) len = high_r;
            else len = low_r;
          end
        endcase
        if (tick_cnt >= len) begin
          tick_cnt = '0;
          if (tx_phase == TxGap) begin
            tx_phase = TxPulse;
          end else if (tx_phase == TxPulse) begin
            tx_phase = TxSpace;
          end else begin
            bit_idx = bit_idx + 5'd1;
            if (bit_idx <= FrameBits + 1) begin
              tx_phase = TxPulse;
            end else if (queued && queued_key != cur_key) begin
              // a different key waiting aborts the rest of the sequence
              r.done_res = 1'b1;
              queued     = 1'b0;
              if (load_key(queued_key)) begin
                r.accepted = 1'b1;
              end else begin
                tx_phase   = TxIdle;
                bit_idx    = '0;
                r.rejected = 1'b1;
              end
            end else begin
              queued = 1'b0;
              if (rep_idx + 1 >= Repeats) begin
                r.done_res = 1'b1;
                tx_phase   = TxIdle;
                bit_idx    = '0;
              end else begin
                rep_idx = rep_idx + 3'd1;
                start_gap();
              end
            end
          end
        end
      end
    end
    r.busy_res = (tx_phase != TxIdle);
    r.frame    = frame_q;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // output side: random stalls and result checking
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[ResW-1:0]);
      if (tx_results_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual %h", $time, got);
      end else begin
        want = tx_results_q.pop_front();
        compare_field("led", want.led, got.led);
        compare_field("busy_res", want.busy_res, got.busy_res);
        compare_field("accepted", want.accepted, got.accepted);
        compare_field("rejected", want.rejected, got.rejected);
        compare_field("frame", want.frame, got.frame);
        compare_field("done_res", want.done_res, got.done_res);
      end
    end
  end

  task automatic send_item(input logic act, input logic [7:0] key);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= key;
    do @(posedge clk_i); while (!s_axis_tready);
    tx_results_q.push_back(advance_transmitter(act, key));
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_item(ActTick, 8'($urandom));
  endtask

  task automatic run_until_idle();
    while (tx_phase != TxIdle) send_item(ActTick, 8'($urandom));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tx_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgChannel:    chan_r  = val[2:0];
      CfgPulse:      pulse_r = val[7:0];
      CfgLowSpace:   low_r   = val[7:0];
      CfgHighSpace:  high_r  = val[7:0];
      CfgStartSpace: start_r = val[7:0];
      CfgSlot:       slot_r  = val;
      default: ;
    endcase
  endtask

  // drains the pipeline, then rewrites every timing register
  task automatic set_timing(input logic [10:0] ch, input logic [10:0] pulse,
                            input logic [10:0] low_sp, input logic [10:0] high_sp,
                            input logic [10:0] start_sp, input logic [10:0] slot);
    wait_drained();
    write_reg(CfgChannel, ch);
    write_reg(CfgPulse, pulse);
    write_reg(CfgLowSpace, low_sp);
    write_reg(CfgHighSpace, high_sp);
    write_reg(CfgStartSpace, start_sp);
    write_reg(CfgSlot, slot);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_traffic(input int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(999);
      if (tx_phase == TxIdle) begin
        if (pick < 700) send_item(ActKey, 8'($urandom_range(KeyLast, KeyFirst)));
        else if (pick < 850) send_item(ActKey, 8'($urandom));
        else send_item(ActTick, 8'($urandom));
      end else if (pick < cmd_permille) begin
        case ($urandom_range(4))
          0, 1:    send_item(ActKey, 8'($urandom_range(KeyLast, KeyFirst)));
          2:       send_item(ActKey, cur_key);
          3:       send_item(ActKey, KeyQuit);
          default: send_item(ActKey, 8'($urandom));
        endcase
      end else begin
        send_item(ActTick, 8'($urandom));
      end
    end
  endtask

  task automatic test_idle_keys();
    send_item(ActKey, 8'd0);
    send_item(ActKey, 8'd48);
    send_item(ActKey, 8'd58);
    send_item(ActKey, KeyQuit);
    send_item(ActKey, 8'd255);
    run_ticks(2);
  endtask

  task automatic test_default_timing();
    send_item(ActKey, 8'd53);
    run_ticks(3);
    // all zero with channel 0, written while the first gap is running
    set_timing(11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0);
    run_ticks(2);
  endtask

  task automatic test_pending_keys();
    run_ticks(5);
    send_item(ActKey, 8'd49);
    send_item(ActKey, KeyQuit);   // only the latest key is kept
    run_until_idle();
    send_item(ActKey, KeyLast);
    run_ticks(10);
    send_item(ActKey, KeyLast);   // same key, dropped at repetition end
    run_ticks(40);
    send_item(ActKey, 8'd50);
    run_ticks(40);
    send_item(ActKey, 8'd0);
    run_until_idle();
  endtask

  task automatic test_channel_range();
    set_timing(11'd7, 11'd1, 11'd1, 11'd2, 11'd3, 11'd1);
    send_item(ActKey, 8'd56);
    run_ticks(3);
    send_item(ActKey, 8'd0);
    run_until_idle();
  endtask

  task automatic test_full_sequences();
    set_timing(11'd4, 11'd1, 11'd1, 11'd1, 11'd1, 11'd1);
    cmd_permille = 0;
    random_traffic(200);
    set_timing(11'd2, 11'($urandom_range(2, 1)), 11'($urandom_range(3, 1)),
               11'($urandom_range(4, 2)), 11'($urandom_range(5, 2)),
               11'($urandom_range(2, 1)));
    random_traffic(150);
  endtask

  task automatic test_sender_gaps();
    idle_pct     = 64;
    cmd_permille = 20;
    set_timing(11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0);
    random_traffic(200);
    idle_pct = 0;
  endtask

  task automatic test_receiver_stalls();
    stall_pct    = 64;
    cmd_permille = 10;
    set_timing(11'($urandom_range(4, 1)), 11'($urandom_range(3, 1)),
               11'($urandom_range(3, 1)), 11'($urandom_range(4, 2)),
               11'($urandom_range(5, 2)), 11'($urandom_range(3, 1)));
    random_traffic(200);
    stall_pct = 0;
  endtask

  task automatic test_extreme_timing();
    idle_pct     = 31;
    stall_pct    = 31;
    cmd_permille = 30;
    set_timing(11'd4, 11'd255, 11'd255, 11'd255, 11'd255, 11'd2047);
    random_traffic(120);
    // shorter lengths land mid-phase, counts already past the end
    cmd_permille = 15;
    set_timing(11'd3, 11'($urandom_range(3, 1)), 11'($urandom_range(3, 1)),
               11'($urandom_range(4, 2)), 11'($urandom_range(5, 2)),
               11'($urandom_range(3, 1)));
    random_traffic(100);
    wait_drained();
    random_traffic(100);
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    while (cycle_cnt < TimeoutCycles) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    cycle_cnt     = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    errors        = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    cmd_permille  = 0;
    chan_r        = 3'd1;
    pulse_r       = 8'd6;
    low_r         = 8'd10;
    high_r        = 8'd21;
    start_r       = 8'd39;
    slot_r        = 11'd608;
    tx_phase      = TxIdle;
    tick_cnt      = '0;
    bit_idx       = '0;
    rep_idx       = '0;
    frame_q       = '0;
    cur_key       = '0;
    queued_key    = '0;
    queued        = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_idle_keys();
    test_default_timing();
    test_pending_keys();
    test_channel_range();
    test_full_sequences();
    test_sender_gaps();
    test_receiver_stalls();
    test_extreme_timing();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ ir_remote_frame_transmitter.f @@
+incdir+hw/rtl
hw/rtl/irtx_pkg.sv
hw/rtl/irtx_frame_enc.sv
hw/rtl/ir_remote_frame_transmitter.sv
test/tb_ir_remote_frame_transmitter.sv
